[rtl/isms_pkg.sv]
// Shared constants, control structs and status structs for the interval scheduler.
package isms_pkg;

  localparam int MAX_MEETINGS_DEF = 64;
  localparam int TIME_BITS_DEF    = 16;
  localparam int COUNT_W          = 7;
  localparam int QUEUE_DEPTH      = 4;

  // per-transaction control, decided by the front end
  typedef struct packed {
    logic keep;   // interval is written to the store
    logic last;   // closes the set
    logic ovf;    // some interval of this set was dropped (valid with last)
  } isms_ctl_t;

  localparam int CTL_W = $bits(isms_ctl_t);

  typedef struct packed {
    logic set_empty;  // no interval held for the open set
  } isms_fstat_t;

  typedef struct packed {
    logic scanning;   // greedy passes in progress
    logic done;       // count final, waiting for the output register
  } isms_bstat_t;

endpackage

[rtl/isms_front.sv]
// Front end: accepts intervals, assigns store slots, flags drops past capacity.
module isms_front #(
  parameter int MAX_MEETINGS = isms_pkg::MAX_MEETINGS_DEF,
  parameter int TIME_BITS    = isms_pkg::TIME_BITS_DEF,
  localparam int IdxW = (MAX_MEETINGS > 1) ? $clog2(MAX_MEETINGS) : 1,
  localparam int CntW = $clog2(MAX_MEETINGS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TIME_BITS-1:0]   in_start_time,
  input  logic [TIME_BITS-1:0]   in_end_time,
  input  logic                   in_last_meeting,
  output logic                   q_push,
  input  logic                   q_space,
  output isms_pkg::isms_ctl_t    q_ctl,
  output logic [TIME_BITS-1:0]   q_start,
  output logic [TIME_BITS-1:0]   q_end,
  output logic [IdxW-1:0]        q_addr,
  output logic [CntW-1:0]        q_cnt,
  output isms_pkg::isms_fstat_t  fstat
);

  logic [CntW-1:0] fill_r, fill_nxt;
  logic            ovf_r, ovf_nxt;
  logic            keep;

  assign keep     = (fill_r < CntW'(MAX_MEETINGS));
  assign in_ready = q_space;
  assign q_push   = in_valid & q_space;

  assign q_ctl.keep = keep;
  assign q_ctl.last = in_last_meeting;
  assign q_ctl.ovf  = ovf_r | ~keep;
  assign q_start    = in_start_time;
  assign q_end      = in_end_time;
  assign q_addr     = fill_r[IdxW-1:0];
  assign q_cnt      = keep ? fill_r + CntW'(1) : fill_r;

  assign fstat.set_empty = (fill_r == '0) && !ovf_r;

  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    if (q_push) begin
      if (in_last_meeting) begin
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end else begin
        fill_nxt = q_cnt;
        ovf_nxt  = q_ctl.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

[rtl/isms_queue.sv]
// Short register FIFO between the front end and the scan engine.
module isms_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         space,
  output logic         head_valid,
  input  logic         pop,
  output logic [W-1:0] head_data
);

  localparam int Depth = isms_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int OccW  = $clog2(Depth + 1);

  logic [W-1:0]    entry_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OccW-1:0] occ_r, occ_nxt;
  logic            do_push, do_pop;

  assign space      = (occ_r != OccW'(Depth));
  assign head_valid = (occ_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push & space;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      occ_nxt = occ_r + OccW'(1);
    end else if (do_pop && !do_push) begin
      occ_nxt = occ_r - OccW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/isms_back.sv]
// Scan engine: interval store, repeated earliest-finish search passes, result register.
module isms_back #(
  parameter int MAX_MEETINGS = isms_pkg::MAX_MEETINGS_DEF,
  parameter int TIME_BITS    = isms_pkg::TIME_BITS_DEF,
  localparam int IdxW = (MAX_MEETINGS > 1) ? $clog2(MAX_MEETINGS) : 1,
  localparam int CntW = $clog2(MAX_MEETINGS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  isms_pkg::isms_ctl_t           q_ctl,
  input  logic [TIME_BITS-1:0]          q_start,
  input  logic [TIME_BITS-1:0]          q_end,
  input  logic [IdxW-1:0]               q_addr,
  input  logic [CntW-1:0]               q_cnt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [isms_pkg::COUNT_W-1:0]  out_meeting_count,
  output logic                          out_overflow,
  output isms_pkg::isms_bstat_t         bstat
);

  localparam int KeyW = 2 * TIME_BITS + IdxW;
  localparam int MemW = 2 * TIME_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [MemW-1:0] mem [MAX_MEETINGS];
  logic [MemW-1:0] rd_data_r;

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] n_r, n_nxt;
  logic [CntW-1:0] rd_idx_r, rd_idx_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [IdxW-1:0] rd_tag_r, rd_tag_nxt;
  logic            any_r, any_nxt;
  logic            found_r, found_nxt;
  logic [KeyW-1:0] cur_key_r, cur_key_nxt;
  logic [KeyW-1:0] best_key_r, best_key_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [isms_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic                 pop, wr_en, issue, pass_end, elig, better, fnd;
  logic [TIME_BITS-1:0] d_start, d_end, bound;
  logic [KeyW-1:0]      cand_key, bk;
  logic [CntW-1:0]      last_idx;

  assign q_ready = (state_r == S_IDLE);
  assign pop     = q_valid & q_ready;
  assign wr_en   = pop & q_ctl.keep;
  assign issue   = (state_r == S_SCAN) && (rd_idx_r < n_r);

  assign d_start  = rd_data_r[MemW-1:TIME_BITS];
  assign d_end    = rd_data_r[TIME_BITS-1:0];
  // key orders by end, then start, then slot; the slot breaks exact duplicates
  assign cand_key = {d_end, d_start, rd_tag_r};
  assign bound    = cur_key_r[KeyW-1:KeyW-TIME_BITS];
  assign last_idx = n_r - CntW'(1);
  assign pass_end = rd_vld_r && (rd_tag_r == last_idx[IdxW-1:0]);

  // first pass takes the smallest key; later passes the smallest key after
  // the last one taken whose start clears the bound
  assign elig   = rd_vld_r && (!any_r || ((cand_key > cur_key_r) && (d_start >= bound)));
  assign better = elig && (!found_r || (cand_key < best_key_r));
  assign fnd    = found_r | better;
  assign bk     = better ? cand_key : best_key_r;

  assign out_valid         = out_valid_r;
  assign out_meeting_count = out_count_r;
  assign out_overflow      = out_ovf_r;
  assign bstat.scanning    = (state_r == S_SCAN);
  assign bstat.done        = (state_r == S_DONE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = issue;
    rd_tag_nxt    = rd_idx_r[IdxW-1:0];
    any_nxt       = any_r;
    found_nxt     = found_r;
    cur_key_nxt   = cur_key_r;
    best_key_nxt  = best_key_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (pop && q_ctl.last) begin
          state_nxt  = S_SCAN;
          n_nxt      = q_cnt;
          ovf_nxt    = q_ctl.ovf;
          count_nxt  = '0;
          any_nxt    = 1'b0;
          found_nxt  = 1'b0;
          rd_idx_nxt = '0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CntW'(1);
        end
        found_nxt    = fnd;
        best_key_nxt = bk;
        if (pass_end) begin
          if (fnd) begin
            count_nxt   = count_r + CntW'(1);
            any_nxt     = 1'b1;
            cur_key_nxt = bk;
            found_nxt   = 1'b0;
            rd_idx_nxt  = '0;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = isms_pkg::COUNT_W'(count_r);
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      any_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      any_r       <= any_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_tag_r   <= rd_tag_nxt;
    cur_key_r  <= cur_key_nxt;
    best_key_r <= best_key_nxt;
    count_r    <= count_nxt;
    ovf_r      <= ovf_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // interval store: one write port from the queue, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_addr] <= {q_start, q_end};
    end
    rd_data_r <= mem[rd_idx_r[IdxW-1:0]];
  end

endmodule

[rtl/interval_scheduling_max_count.sv]
// Top level of the interval scheduler: maximum count of non-overlapping intervals.
//
// Usage: intervals arrive on the in_ channel (valid/ready), one start/end pair
// per transaction; in_last_meeting closes the set. One out_ transaction then
// carries the greedy earliest-finish count and a flag telling whether any
// interval of the set was dropped because MAX_MEETINGS were already held.
// Loading: one interval per cycle into a 4-entry queue while it has space;
// the scan engine drains it into the interval store at one entry per cycle while idle.
// Scan: after the closing transaction the engine makes one pass over the n
// stored intervals per interval taken, plus one final pass that finds none.
// Each pass makes one registered store read per entry. The front end keeps
// taking intervals of the next set into the queue while a scan runs.
// Back pressure: a finished count waits in the output register until out_ready
// takes it; the engine stalls the queue only while a newer count waits for that
// register, and the front end stalls in_ready only when the queue is full.
// Reset (rst_n low, synchronous): queue, fill count, drop flag and output
// valid clear; the store contents are not cleared and need no sweep.
module interval_scheduling_max_count #(
  parameter int MAX_MEETINGS = isms_pkg::MAX_MEETINGS_DEF,
  parameter int TIME_BITS    = isms_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [TIME_BITS-1:0]          in_start_time,
  input  logic [TIME_BITS-1:0]          in_end_time,
  input  logic                          in_last_meeting,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [isms_pkg::COUNT_W-1:0]  out_meeting_count,
  output logic                          out_overflow
);

  localparam int IdxW = (MAX_MEETINGS > 1) ? $clog2(MAX_MEETINGS) : 1;
  localparam int CntW = $clog2(MAX_MEETINGS + 1);
  localparam int QW   = isms_pkg::CTL_W + 2 * TIME_BITS + IdxW + CntW;

  // front end -> queue
  logic                  f_push, q_space;
  isms_pkg::isms_ctl_t   f_ctl;
  logic [TIME_BITS-1:0]  f_start, f_end;
  logic [IdxW-1:0]       f_addr;
  logic [CntW-1:0]       f_cnt;
  isms_pkg::isms_fstat_t fstat;

  // queue -> scan engine
  logic                  q_valid, b_ready, q_pop;
  logic [QW-1:0]         q_in, q_out;
  isms_pkg::isms_ctl_t   b_ctl;
  logic [TIME_BITS-1:0]  b_start, b_end;
  logic [IdxW-1:0]       b_addr;
  logic [CntW-1:0]       b_cnt;
  isms_pkg::isms_bstat_t bstat;

  isms_front #(
    .MAX_MEETINGS (MAX_MEETINGS),
    .TIME_BITS    (TIME_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_time   (in_start_time),
    .in_end_time     (in_end_time),
    .in_last_meeting (in_last_meeting),
    .q_push          (f_push),
    .q_space         (q_space),
    .q_ctl           (f_ctl),
    .q_start         (f_start),
    .q_end           (f_end),
    .q_addr          (f_addr),
    .q_cnt           (f_cnt),
    .fstat           (fstat)
  );

  assign q_in = {f_ctl, f_start, f_end, f_addr, f_cnt};

  isms_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  (q_in),
    .space      (q_space),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_data  (q_out)
  );

  assign {b_ctl, b_start, b_end, b_addr, b_cnt} = q_out;
  assign q_pop = q_valid & b_ready;

  isms_back #(
    .MAX_MEETINGS (MAX_MEETINGS),
    .TIME_BITS    (TIME_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (b_ready),
    .q_ctl             (b_ctl),
    .q_start           (b_start),
    .q_end             (b_end),
    .q_addr            (b_addr),
    .q_cnt             (b_cnt),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_meeting_count (out_meeting_count),
    .out_overflow      (out_overflow),
    .bstat             (bstat)
  );

  // closing a set leaves the front end with an empty fill count and no drop flag
  a_set_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_meeting) |=> fstat.set_empty)
    else $error("front end did not reopen after the closing transaction");

  // the store must not change under a running scan
  a_no_pop_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.scanning |-> !q_pop)
    else $error("queue drained while scan passes run");

  // a result only appears once the scan has finished
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bstat.done))
    else $error("result raised without a finished scan");

endmodule

[bench/isms_checker.sv]
`timescale 1ns / 1ps
// Interval scheduler checker: predicts the greedy count per set and compares out_ transactions.
module isms_checker #(
  parameter int MAX_MEETINGS = isms_pkg::MAX_MEETINGS_DEF,
  parameter int TIME_BITS    = isms_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [TIME_BITS-1:0]          in_start_time,
  input  logic [TIME_BITS-1:0]          in_end_time,
  input  logic                          in_last_meeting,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [isms_pkg::COUNT_W-1:0]  out_meeting_count,
  input  logic                          out_overflow,
  output int unsigned                   pending_results,
  output int unsigned                   mismatch_count
);

  localparam int IdxW = (MAX_MEETINGS > 1) ? $clog2(MAX_MEETINGS) : 1;

  typedef struct packed {
    logic [isms_pkg::COUNT_W-1:0] count;
    logic                         dropped;
  } set_result_t;

  logic [TIME_BITS-1:0] held_start [MAX_MEETINGS];
  logic [TIME_BITS-1:0] held_end   [MAX_MEETINGS];
  int unsigned          held_n = 0;
  logic                 drop_seen = 1'b0;
  set_result_t          result_q [$];
  set_result_t          want;
  int unsigned          errs = 0;

  // earliest finish first, ties by ascending start, then greedy selection
  function automatic logic [isms_pkg::COUNT_W-1:0] max_disjoint_count(int unsigned n);
    logic [TIME_BITS-1:0] st [MAX_MEETINGS];
    logic [TIME_BITS-1:0] en [MAX_MEETINGS];
    logic [TIME_BITS-1:0] ks, ke, bound;
    int unsigned          j, taken;
    st = held_start;
    en = held_end;
    for (int unsigned i = 1; i < n; i++) begin
      ks = st[IdxW'(i)];
      ke = en[IdxW'(i)];
      j  = i;
      while (j > 0 && ((ke < en[IdxW'(j-1)]) ||
                       (ke == en[IdxW'(j-1)] && ks < st[IdxW'(j-1)]))) begin
        st[IdxW'(j)] = st[IdxW'(j-1)];
        en[IdxW'(j)] = en[IdxW'(j-1)];
        j--;
      end
      st[IdxW'(j)] = ks;
      en[IdxW'(j)] = ke;
    end
    taken = 0;
    bound = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (taken == 0 || st[IdxW'(i)] >= bound) begin
        taken++;
        bound = en[IdxW'(i)];
      end
    end
    return isms_pkg::COUNT_W'(taken);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held_n    = 0;
      drop_seen = 1'b0;
      result_q.delete();
    end else begin
      // results first: a set closed at this edge cannot already be answered
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result meeting_count %0d overflow %0b",
                   $time, out_meeting_count, out_overflow);
          errs++;
        end else begin
          want = result_q.pop_front();
          if (out_meeting_count !== want.count) begin
            $display("%0t: meeting_count mismatch expected %0d actual %0d",
                     $time, want.count, out_meeting_count);
            errs++;
          end
          if (out_overflow !== want.dropped) begin
            $display("%0t: overflow mismatch expected %0b actual %0b",
                     $time, want.dropped, out_overflow);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (held_n < MAX_MEETINGS) begin
          held_start[IdxW'(held_n)] = in_start_time;
          held_end[IdxW'(held_n)]   = in_end_time;
          held_n++;
        end else begin
          drop_seen = 1'b1;
        end
        if (in_last_meeting) begin
          want.count   = max_disjoint_count(held_n);
          want.dropped = drop_seen;
          result_q.push_back(want);
          held_n    = 0;
          drop_seen = 1'b0;
        end
      end
    end
    pending_results <= result_q.size();
    mismatch_count  <= errs;
  end

endmodule

[bench/tb_interval_scheduling_max_count.sv]
`timescale 1ns / 1ps
// Testbench top for the interval scheduler: clock, reset, stimulus, result stalls and verdict.
module tb_interval_scheduling_max_count;

  localparam int MAXM         = isms_pkg::MAX_MEETINGS_DEF;
  localparam int TB_TIME_BITS = isms_pkg::TIME_BITS_DEF;
  localparam int RANDOM_ITEMS = 1250;
  // worst correct run is far below this: the scan passes of full sets, plus
  // the longest sender gap and receiver stall per transaction
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int TAIL_CYCLES  = 300;

  // set flavors of the random part
  typedef enum int {
    TIMES_FULL_RANGE,
    TIMES_CROWDED,
    TIMES_PROPER,
    TIMES_EXTREME
  } time_mix_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [TB_TIME_BITS-1:0]       in_start_time = '0;
  logic [TB_TIME_BITS-1:0]       in_end_time = '0;
  logic                          in_last_meeting = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [isms_pkg::COUNT_W-1:0]  out_meeting_count;
  logic                          out_overflow;

  int unsigned              pending_results;
  int unsigned              mismatch_count;
  int unsigned              cycle_count = 0;
  int unsigned              items_sent = 0;
  int unsigned              ready_hold = 0;
  bit                       no_idle = 1'b0;

  always #4 clk = ~clk;

  interval_scheduling_max_count #(
    .MAX_MEETINGS (MAXM),
    .TIME_BITS    (TB_TIME_BITS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_time     (in_start_time),
    .in_end_time       (in_end_time),
    .in_last_meeting   (in_last_meeting),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_meeting_count (out_meeting_count),
    .out_overflow      (out_overflow)
  );

  isms_checker #(
    .MAX_MEETINGS (MAXM),
    .TIME_BITS    (TB_TIME_BITS)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_time     (in_start_time),
    .in_end_time       (in_end_time),
    .in_last_meeting   (in_last_meeting),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_meeting_count (out_meeting_count),
    .out_overflow      (out_overflow),
    .pending_results   (pending_results),
    .mismatch_count    (mismatch_count)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side back pressure. Each run of ready/not-ready holds for a
  // random length: mostly short stalls, a few long ones, and now and then
  // a long stretch with out_ready held high so results stream freely.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 99)) inside
        [0:49]: begin
          out_ready  <= 1'b1;
          ready_hold = $urandom_range(1, 20);
        end
        [50:84]: begin
          out_ready  <= 1'b0;
          ready_hold = $urandom_range(1, 3);
        end
        [85:94]: begin
          out_ready  <= 1'b0;
          ready_hold = $urandom_range(10, 60);
        end
        default: begin
          out_ready  <= 1'b1;
          ready_hold = $urandom_range(200, 600);
        end
      endcase
    end else begin
      ready_hold = ready_hold - 1;
    end
  end

  // Sender gap after a transaction: none inside a no-idle stretch, otherwise
  // mostly none or short, occasionally long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one interval and hold it until the transaction completes. The
  // valid stays up into the next call when no gap follows, so valid is
  // never dropped and raised in the same time step.
  task automatic send_interval(input logic [TB_TIME_BITS-1:0] s,
                               input logic [TB_TIME_BITS-1:0] e,
                               input logic last);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_start_time   <= s;
    in_end_time     <= e;
    in_last_meeting <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every closed set has been answered. It first
  // waits for the checker to register the set just closed.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // One time value biased to the ends of the range.
  function automatic logic [TB_TIME_BITS-1:0] edge_time();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return TB_TIME_BITS'(1);
      3: return {TB_TIME_BITS{1'b1}} - TB_TIME_BITS'(1);
      default: return TB_TIME_BITS'($urandom());
    endcase
  endfunction

  task automatic make_interval(input time_mix_t mix,
                               output logic [TB_TIME_BITS-1:0] s,
                               output logic [TB_TIME_BITS-1:0] e);
    case (mix)
      TIMES_FULL_RANGE: begin
        s = TB_TIME_BITS'($urandom());
        e = TB_TIME_BITS'($urandom());
      end
      // small window: many equal ends and touching intervals, some reversed
      TIMES_CROWDED: begin
        s = TB_TIME_BITS'($urandom_range(0, 31));
        e = TB_TIME_BITS'($urandom_range(0, 40));
      end
      TIMES_PROPER: begin
        s = TB_TIME_BITS'($urandom_range(0, 65000));
        e = s + TB_TIME_BITS'($urandom_range(0, 500));
      end
      default: begin
        s = edge_time();
        e = edge_time();
      end
    endcase
  endtask

  initial begin
    int unsigned                set_size;
    int unsigned                r;
    time_mix_t                  mix;
    logic [TB_TIME_BITS-1:0]    s, e;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets.
    // single intervals at both ends of the time range
    send_interval('0, '0, 1'b1);
    send_interval('1, '1, 1'b1);
    // start after end is compared like any other interval
    send_interval('1, '0, 1'b0);
    send_interval('0, '1, 1'b1);
    // equal end times, one zero-length interval, one touching the tie
    send_interval(16'd5, 16'd10, 1'b0);
    send_interval(16'd3, 16'd10, 1'b0);
    send_interval(16'd10, 16'd10, 1'b0);
    send_interval(16'd10, 16'd20, 1'b0);
    send_interval(16'd0, 16'd5, 1'b1);
    // touching chain plus one interval overlapping all three links
    send_interval(16'd0, 16'd5, 1'b0);
    send_interval(16'd5, 16'd10, 1'b0);
    send_interval(16'd10, 16'd15, 1'b0);
    send_interval(16'd3, 16'd12, 1'b1);
    // alternating bit patterns
    send_interval(16'hAAAA, 16'h5555, 1'b0);
    send_interval(16'h5555, 16'hAAAA, 1'b1);

    // sender waits out every pending result at least once
    drain_results();

    // Random sets: mostly small, some medium, some exactly full, some past
    // capacity so that trailing intervals (the closing one too) are dropped.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      set_size = $urandom_range(1, 12);
      else if (r < 85) set_size = $urandom_range(13, 40);
      else if (r < 92) set_size = MAXM;
      else             set_size = $urandom_range(MAXM + 1, MAXM + 8);
      mix     = time_mix_t'($urandom_range(0, 3));
      no_idle = ($urandom_range(0, 4) == 0);
      for (int unsigned i = 0; i < set_size; i++) begin
        make_interval(mix, s, e);
        send_interval(s, e, i == set_size - 1);
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    // Wrap up: all sets are closed; wait for their counts, then watch a
    // while longer for stray results.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
